@@ rtl/abrt_pkg.sv @@
// ----------------------------------------------------------------------------
// abrt_pkg
// shared widths, codes and types of the ack bitmap retransmit tracker
// ----------------------------------------------------------------------------
package abrt_pkg;

	localparam int MAX_PACKETS_DEF = 64;
	localparam int CHUNK_BYTES_DEF = 1024;

	localparam int TOTAL_W    = 7;
	localparam int TAIL_W     = 10;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OP_W       = 2;
	localparam int ACK_W      = 8;
	localparam int PNUM_W     = 6;
	localparam int OFFSET_W   = 16;
	localparam int CHUNK_W    = 11;
	localparam int ROUND_W    = 16;

	localparam logic [TOTAL_W-1:0]    TOTAL_RESET    = 7'd1;
	localparam logic [TAIL_W-1:0]     TAIL_RESET     = 10'd0;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              set_all;
		logic              set_one;
		logic [PNUM_W-1:0] idx;
		logic [PNUM_W-1:0] pos;
	} map_cmd_t;

	typedef struct packed {
		logic all_done;
		logic pos_acked;
		logic more_after;
	} map_stat_t;

endpackage

@@ rtl/abrt_ifs.sv @@
// ----------------------------------------------------------------------------
// abrt_ifs
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface abrt_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [abrt_pkg::OP_W-1:0]        op;
	logic signed [abrt_pkg::ACK_W-1:0] ack_number;

	modport source (output valid, op, ack_number, input ready);
	modport sink   (input valid, op, ack_number, output ready);
endinterface

interface abrt_res_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [abrt_pkg::PNUM_W-1:0]      packet_number;
	logic [abrt_pkg::OFFSET_W-1:0]    byte_offset;
	logic [abrt_pkg::CHUNK_W-1:0]     chunk_bytes;
	logic                             is_resend;
	logic                             all_acked;
	logic                             ack_error;
	logic [abrt_pkg::ROUND_W-1:0]     rounds_done;
	logic                             last;

	modport source (output valid, kind, packet_number, byte_offset, chunk_bytes, is_resend,
		all_acked, ack_error, rounds_done, last, input ready);
	modport sink   (input valid, kind, packet_number, byte_offset, chunk_bytes, is_resend,
		all_acked, ack_error, rounds_done, last, output ready);
endinterface

@@ rtl/ack_bitmap_retransmit_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// ack_bitmap_retransmit_tracker_unit
// selective repeat sender tracker: config registers, ack map and scan sequencer
// ----------------------------------------------------------------------------
// start: accept, then one packet per cycle over n packets while result items are taken
// ack: map update at accept, status report from the report state once the slot is free
// tick: counts down the timer; expiring with every packet acked, it reports like an ack;
//   with missing packets it scans n positions, one per cycle; resends wait for a free slot
// a held result item stalls both the packet scan and the status report
// reset: async, clears the ack map, timer, round count and config to defaults
module ack_bitmap_retransmit_tracker_unit #(
	parameter int MAX_PACKETS = abrt_pkg::MAX_PACKETS_DEF,
	parameter int CHUNK_BYTES = abrt_pkg::CHUNK_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [abrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abrt_pkg::CFG_DATA_W-1:0] cfg_data,
	abrt_cmd_if.sink                        cmd,
	abrt_res_if.source                      result
);

	logic [abrt_pkg::TOTAL_W-1:0]    total_q;
	logic [abrt_pkg::TAIL_W-1:0]     tail_q;
	logic [abrt_pkg::INTERVAL_W-1:0] interval_q;
	logic [abrt_pkg::TOTAL_W-1:0]    n_eff;

	abrt_pkg::map_cmd_t  mcmd;
	abrt_pkg::map_stat_t mstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= abrt_pkg::TOTAL_RESET;
			tail_q     <= abrt_pkg::TAIL_RESET;
			interval_q <= abrt_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				abrt_pkg::CFG_TOTAL:    total_q    <= cfg_data[abrt_pkg::TOTAL_W-1:0];
				abrt_pkg::CFG_TAIL:     tail_q     <= cfg_data[abrt_pkg::TAIL_W-1:0];
				abrt_pkg::CFG_INTERVAL: interval_q <= cfg_data[abrt_pkg::INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp packet count into 1..MAX_PACKETS
	always_comb begin
		if (total_q == '0) begin
			n_eff = abrt_pkg::TOTAL_W'(1);
		end else if (total_q > abrt_pkg::TOTAL_W'(MAX_PACKETS)) begin
			n_eff = abrt_pkg::TOTAL_W'(MAX_PACKETS);
		end else begin
			n_eff = total_q;
		end
	end

	abrt_map #(
		.MAX_PACKETS(MAX_PACKETS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.n      (n_eff),
		.cmd    (mcmd),
		.stat   (mstat)
	);

	abrt_seq #(
		.MAX_PACKETS(MAX_PACKETS),
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.result   (result),
		.n        (n_eff),
		.tail     (tail_q),
		.interval (interval_q),
		.mcmd     (mcmd),
		.mstat    (mstat)
	);

	a_start_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.op == abrt_pkg::OP_START) |=> !cmd.ready)
		else $error("start item did not begin a send scan");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind == abrt_pkg::KIND_STATUS) |-> result.last)
		else $error("status report not marked last");

	a_pkt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind == abrt_pkg::KIND_PACKET)
			|-> (abrt_pkg::TOTAL_W'(result.packet_number) < n_eff))
		else $error("packet number beyond message length");

endmodule

@@ rtl/abrt_map.sv @@
// ----------------------------------------------------------------------------
// abrt_map
// acknowledge bitmap with done check and scan lookahead
// ----------------------------------------------------------------------------
module abrt_map #(
	parameter int MAX_PACKETS = abrt_pkg::MAX_PACKETS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [abrt_pkg::TOTAL_W-1:0]   n,
	input  abrt_pkg::map_cmd_t             cmd,
	output abrt_pkg::map_stat_t            stat
);

	localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;

	logic [MAX_PACKETS-1:0] map_q;
	logic [MAX_PACKETS-1:0] mask;
	logic [MAX_PACKETS-1:0] above;

	always_comb begin
		for (int i = 0; i < MAX_PACKETS; i++) begin
			mask[i]  = abrt_pkg::TOTAL_W'(i) < n;
			above[i] = abrt_pkg::TOTAL_W'(i) > abrt_pkg::TOTAL_W'(cmd.pos);
		end
	end

	always_comb begin
		stat.all_done   = &(map_q | ~mask);
		stat.pos_acked  = map_q[cmd.pos[PW-1:0]];
		stat.more_after = |(~map_q & mask & above);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (cmd.clear) begin
			map_q <= '0;
		end else if (cmd.set_all) begin
			map_q <= map_q | mask;
		end else if (cmd.set_one) begin
			map_q[cmd.idx[PW-1:0]] <= 1'b1;
		end
	end

endmodule

@@ rtl/abrt_seq.sv @@
// ----------------------------------------------------------------------------
// abrt_seq
// command decode, scan sequencer, resend timer and result register
// ----------------------------------------------------------------------------
module abrt_seq #(
	parameter int MAX_PACKETS = abrt_pkg::MAX_PACKETS_DEF,
	parameter int CHUNK_BYTES = abrt_pkg::CHUNK_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	abrt_cmd_if.sink                        cmd,
	abrt_res_if.source                      result,
	input  logic [abrt_pkg::TOTAL_W-1:0]    n,
	input  logic [abrt_pkg::TAIL_W-1:0]     tail,
	input  logic [abrt_pkg::INTERVAL_W-1:0] interval,
	output abrt_pkg::map_cmd_t              mcmd,
	input  abrt_pkg::map_stat_t             mstat
);

	localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
	localparam logic [abrt_pkg::OFFSET_W-1:0] CHUNK_LO = abrt_pkg::OFFSET_W'(CHUNK_BYTES);
	localparam logic [abrt_pkg::CHUNK_W-1:0]  CHUNK_LEN = abrt_pkg::CHUNK_W'(CHUNK_BYTES);

	abrt_pkg::state_t state_q, state_d;

	logic [PW-1:0]                     pos_q;
	logic                              resend_q;
	logic                              err_q;
	logic [abrt_pkg::INTERVAL_W-1:0]   interval_q;
	logic [abrt_pkg::ROUND_W-1:0]      round_q;
	logic                              out_valid_q;

	logic                              accept, is_start, is_ack, is_tick;
	logic                              ack_all, ack_err;
	logic                              tick_live, tick_expire, tick_report, tick_round;
	logic                              slot_free, pos_last, skip, step;
	logic                              emit_pkt, emit_rep;
	logic [abrt_pkg::INTERVAL_W-1:0]   load_val;
	logic [abrt_pkg::OFFSET_W-1:0]     offset;
	logic [abrt_pkg::CHUNK_W-1:0]      len;

	assign slot_free = !out_valid_q || result.ready;
	assign pos_last  = abrt_pkg::TOTAL_W'(pos_q) == (n - abrt_pkg::TOTAL_W'(1));
	assign load_val  = (interval == '0) ? abrt_pkg::INTERVAL_W'(1) : interval;
	assign offset    = abrt_pkg::OFFSET_W'(pos_q) * CHUNK_LO;
	assign len       = (pos_last && tail != '0) ? abrt_pkg::CHUNK_W'(tail) : CHUNK_LEN;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			abrt_pkg::ST_IDLE: begin
				if (is_start || tick_round) begin
					state_d = abrt_pkg::ST_SCAN;
				end else if (is_ack || tick_report) begin
					state_d = abrt_pkg::ST_REPORT;
				end
			end
			abrt_pkg::ST_SCAN: begin
				if (step && pos_last) begin
					state_d = abrt_pkg::ST_IDLE;
				end
			end
			abrt_pkg::ST_REPORT: begin
				if (slot_free) begin
					state_d = abrt_pkg::ST_IDLE;
				end
			end
			default: state_d = abrt_pkg::ST_IDLE;
		endcase
	end

	// outputs and decode
	always_comb begin
		cmd.ready   = (state_q == abrt_pkg::ST_IDLE);
		accept      = cmd.valid && cmd.ready;
		is_start    = accept && (cmd.op == abrt_pkg::OP_START);
		is_ack      = accept && (cmd.op == abrt_pkg::OP_ACK);
		is_tick     = accept && (cmd.op == abrt_pkg::OP_TICK);
		ack_all     = cmd.ack_number[abrt_pkg::ACK_W-1];
		ack_err     = !ack_all && (abrt_pkg::TOTAL_W'(cmd.ack_number[abrt_pkg::ACK_W-2:0]) >= n);
		tick_live   = is_tick && (interval_q != '0);
		tick_expire = tick_live && (interval_q == abrt_pkg::INTERVAL_W'(1));
		tick_report = tick_expire && mstat.all_done;
		tick_round  = tick_expire && !mstat.all_done;

		mcmd.clear   = is_start;
		mcmd.set_all = is_ack && ack_all;
		mcmd.set_one = is_ack && !ack_all && !ack_err;
		mcmd.idx     = cmd.ack_number[abrt_pkg::PNUM_W-1:0];
		mcmd.pos     = abrt_pkg::PNUM_W'(pos_q);

		skip     = resend_q && mstat.pos_acked;
		step     = (state_q == abrt_pkg::ST_SCAN) && (skip || slot_free);
		emit_pkt = (state_q == abrt_pkg::ST_SCAN) && !skip && slot_free;
		emit_rep = (state_q == abrt_pkg::ST_REPORT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abrt_pkg::ST_IDLE;
			pos_q       <= '0;
			resend_q    <= 1'b0;
			err_q       <= 1'b0;
			interval_q  <= '0;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (is_start) begin
				round_q    <= '0;
				interval_q <= load_val;
				resend_q   <= 1'b0;
				pos_q      <= '0;
			end
			if (is_ack) begin
				err_q <= ack_err;
			end
			if (tick_live) begin
				err_q <= 1'b0;
				if (tick_round) begin
					interval_q <= load_val;
					resend_q   <= 1'b1;
					pos_q      <= '0;
					if (round_q != '1) begin
						round_q <= round_q + abrt_pkg::ROUND_W'(1);
					end
				end else begin
					interval_q <= interval_q - abrt_pkg::INTERVAL_W'(1);
				end
			end
			if (step) begin
				pos_q <= pos_last ? '0 : pos_q + PW'(1);
			end
			if (emit_pkt || emit_rep) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit_pkt) begin
			result.kind          <= abrt_pkg::KIND_PACKET;
			result.packet_number <= abrt_pkg::PNUM_W'(pos_q);
			result.byte_offset   <= offset;
			result.chunk_bytes   <= len;
			result.is_resend     <= resend_q;
			result.all_acked     <= mstat.all_done;
			result.ack_error     <= 1'b0;
			result.rounds_done   <= round_q;
			result.last          <= resend_q ? !mstat.more_after : pos_last;
		end else if (emit_rep) begin
			result.kind          <= abrt_pkg::KIND_STATUS;
			result.packet_number <= '0;
			result.byte_offset   <= '0;
			result.chunk_bytes   <= '0;
			result.is_resend     <= 1'b0;
			result.all_acked     <= mstat.all_done;
			result.ack_error     <= err_q;
			result.rounds_done   <= round_q;
			result.last          <= 1'b1;
		end
	end

	assign result.valid = out_valid_q;

endmodule
